FILE: src/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared constants and types for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

  // Header geometry
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned PosW     = 5;

  // Byte positions of interest (wire order)
  localparam logic [PosW-1:0] PosTotLenLo = 5'd3;
  localparam logic [PosW-1:0] PosFragLo   = 5'd7;
  localparam logic [PosW-1:0] PosProto    = 5'd9;
  localparam logic [PosW-1:0] PosCsumLo   = 5'd11;
  localparam logic [PosW-1:0] PosSrcFirst = 5'd12;
  localparam logic [PosW-1:0] PosSrcLast  = 5'd15;
  localparam logic [PosW-1:0] PosLast     = 5'd19;
  localparam logic [PosW-1:0] PosDone     = 5'd20;

  // Checksum constants
  localparam int unsigned     SumW     = 20;
  localparam logic [15:0]     WordMask = 16'hFFFF;

  // Protocol numbers
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // Verdict codes
  localparam logic [1:0] VerdictAccept   = 2'd0;
  localparam logic [1:0] VerdictBadCsum  = 2'd1;
  localparam logic [1:0] VerdictUnknown  = 2'd2;
  localparam logic [1:0] VerdictFragIcmp = 2'd3;

  // Protocol class codes
  localparam logic [1:0] ClassTcp   = 2'd0;
  localparam logic [1:0] ClassUdp   = 2'd1;
  localparam logic [1:0] ClassIcmp  = 2'd2;
  localparam logic [1:0] ClassOther = 2'd3;

  // Header summary handed from the parser to the verdict stage
  typedef struct packed {
    logic [SumW-1:0] word_sum;
    logic [15:0]     rx_csum;
    logic [15:0]     total_len;
    logic [15:0]     frag_word;
    logic [7:0]      proto;
    logic [31:0]     src_addr;
  } hdr_t;

endpackage

FILE: src/ihc_intf.sv
// ----------------------------------------------------------------------------
// ihc_intf
// Valid/ready channel interfaces for header bytes and verdicts.
// ----------------------------------------------------------------------------
interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       first_byte;

  modport source (output valid, output header_byte, output first_byte, input ready);
  modport sink   (input valid, input header_byte, input first_byte, output ready);
endinterface

interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [1:0]  protocol_class;
  logic [15:0] payload_length;
  logic [31:0] source_address;

  modport source (output valid, output verdict, output protocol_class,
                  output payload_length, output source_address, input ready);
  modport sink   (input valid, input verdict, input protocol_class,
                  input payload_length, input source_address, output ready);
endinterface

FILE: src/ihc_parse.sv
// ----------------------------------------------------------------------------
// ihc_parse
// Byte tracker: running word sum and field capture across one header.
// ----------------------------------------------------------------------------
module ihc_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    byte_i,
  input  logic          first_i,
  output logic          done_o,
  output ihc_pkg::hdr_t hdr_o
);

  logic [ihc_pkg::PosW-1:0] pos_q, pos_d, pos_base;
  logic [7:0]               hold_q, hold_d, hold_base;
  ihc_pkg::hdr_t            hdr_q, hdr_d, hdr_base;
  logic [15:0]              word;
  logic                     active;

  // Restart on a first-byte flag, otherwise continue from held state
  always_comb begin
    pos_base  = first_i ? '0 : pos_q;
    hold_base = first_i ? '0 : hold_q;
    hdr_base  = first_i ? '0 : hdr_q;
  end

  assign active = (pos_base < ihc_pkg::PosDone);
  assign word   = {hold_base, byte_i};

  // Update sum and captured fields for the current byte
  always_comb begin
    pos_d  = pos_base;
    hold_d = hold_base;
    hdr_d  = hdr_base;
    if (active) begin
      if (!pos_base[0]) begin
        hold_d = byte_i;
      end else begin
        if (pos_base == ihc_pkg::PosCsumLo) begin
          hdr_d.rx_csum = word;
        end else begin
          hdr_d.word_sum = hdr_base.word_sum + ihc_pkg::SumW'(word);
        end
        if (pos_base == ihc_pkg::PosTotLenLo) begin
          hdr_d.total_len = word;
        end else if (pos_base == ihc_pkg::PosFragLo) begin
          hdr_d.frag_word = word;
        end
      end
      if (pos_base == ihc_pkg::PosProto) begin
        hdr_d.proto = byte_i;
      end
      if (pos_base >= ihc_pkg::PosSrcFirst && pos_base <= ihc_pkg::PosSrcLast) begin
        hdr_d.src_addr = {hdr_base.src_addr[23:0], byte_i};
      end
      pos_d = pos_base + 1'b1;
    end
  end

  // Hold header state; advance on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hold_q <= '0;
      hdr_q  <= '0;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      hold_q <= hold_d;
      hdr_q  <= hdr_d;
    end
  end

  assign done_o = adv_i && (pos_base == ihc_pkg::PosLast);
  assign hdr_o  = hdr_d;

endmodule

FILE: src/ihc_verdict.sv
// ----------------------------------------------------------------------------
// ihc_verdict
// Checksum fold, protocol classification and the result register.
// ----------------------------------------------------------------------------
module ihc_verdict (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ihc_pkg::hdr_t hdr_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [1:0]    verdict_o,
  output logic [1:0]    class_o,
  output logic [15:0]   payload_o,
  output logic [31:0]   src_addr_o
);

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum_calc;
  logic [1:0]  cls;
  logic [1:0]  verdict;
  logic [15:0] payload;
  logic        valid_q;
  logic [1:0]  verdict_q, class_q;
  logic [15:0] payload_q;
  logic [31:0] src_q;

  // Fold the carry twice: the second fold can no longer overflow
  always_comb begin
    fold1     = {1'b0, hdr_i.word_sum[15:0]} + 17'(hdr_i.word_sum[ihc_pkg::SumW-1:16]);
    fold2     = fold1[15:0] + 16'(fold1[16]);
    csum_calc = ~fold2 & ihc_pkg::WordMask;
  end

  // Classify the protocol
  always_comb begin
    case (hdr_i.proto)
      ihc_pkg::ProtoTcp:  cls = ihc_pkg::ClassTcp;
      ihc_pkg::ProtoUdp:  cls = ihc_pkg::ClassUdp;
      ihc_pkg::ProtoIcmp: cls = ihc_pkg::ClassIcmp;
      default:            cls = ihc_pkg::ClassOther;
    endcase
  end

  // Pick the verdict; a checksum mismatch wins
  always_comb begin
    if (csum_calc != hdr_i.rx_csum) begin
      verdict = ihc_pkg::VerdictBadCsum;
    end else if (cls == ihc_pkg::ClassOther) begin
      verdict = ihc_pkg::VerdictUnknown;
    end else if (cls == ihc_pkg::ClassIcmp && hdr_i.frag_word != '0) begin
      verdict = ihc_pkg::VerdictFragIcmp;
    end else begin
      verdict = ihc_pkg::VerdictAccept;
    end
  end

  // Payload length saturates at zero
  assign payload = (hdr_i.total_len > 16'(ihc_pkg::HdrBytes))
                 ? hdr_i.total_len - 16'(ihc_pkg::HdrBytes) : '0;

  // Result valid: set on load, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict;
      class_q   <= cls;
      payload_q <= payload;
      src_q     <= hdr_i.src_addr;
    end
  end

  assign valid_o    = valid_q;
  assign verdict_o  = verdict_q;
  assign class_o    = class_q;
  assign payload_o  = payload_q;
  assign src_addr_o = src_q;

endmodule

FILE: src/ipv4_header_checker_top.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker_top
// Streaming IPv4 header checksum check and protocol classification.
// ----------------------------------------------------------------------------
// Takes one header byte per transfer, one byte per cycle sustained. Each byte
// lands in an input register, then updates the running ones-complement sum and
// the captured fields. When the twentieth byte of a header leaves the input
// register, it loads the verdict into the result register, which offers it.
// Byte input stalls whenever a verdict waits on the output without a transfer,
// at any byte position, and resumes in the cycle the verdict is taken. No reset
// sweep is needed.
// ----------------------------------------------------------------------------
module ipv4_header_checker_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  ihc_in_if.sink          hdr_i,
  ihc_out_if.source       res_o
);

  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          in_first_q;
  logic          adv;
  logic          done;
  logic          res_vld;
  logic          res_pop;
  ihc_pkg::hdr_t hdr;

  // Advance the held byte unless a waiting verdict blocks it
  assign res_pop     = res_vld && res_o.ready;
  assign adv         = in_vld_q && (!res_vld || res_o.ready);
  assign hdr_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (hdr_i.ready) begin
      in_vld_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.ready && hdr_i.valid) begin
      in_byte_q  <= hdr_i.header_byte;
      in_first_q <= hdr_i.first_byte;
    end
  end

  ihc_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .first_i (in_first_q),
    .done_o  (done),
    .hdr_o   (hdr)
  );

  ihc_verdict u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (done),
    .hdr_i      (hdr),
    .pop_i      (res_pop),
    .valid_o    (res_vld),
    .verdict_o  (res_o.verdict),
    .class_o    (res_o.protocol_class),
    .payload_o  (res_o.payload_length),
    .src_addr_o (res_o.source_address)
  );

  assign res_o.valid = res_vld;

endmodule

FILE: bench/ipv4_header_checker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_header_checker_top_tb
// Self-checking bench for the streaming IPv4 header checker. Header bytes are
// pushed through the byte channel with random gaps. A scoreboard tracks the
// header state byte by byte and queues the verdict each header should give.
// Every verdict transfer is checked field by field against the oldest
// queued verdict.
// ----------------------------------------------------------------------------
module ipv4_header_checker_top_tb;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 10;
  localparam int ByteBudget  = 800;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 20;
  localparam int SumW        = ihc_pkg::SumW;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  protocol_class;
    logic [15:0] payload_length;
    logic [31:0] source_address;
  } verdict_t;

  // Header state tracker and queue of verdicts still owed by the block
  class ipv4_verdict_scoreboard;
    logic [ihc_pkg::PosW-1:0] pos;
    logic [SumW-1:0]          sum;
    logic [7:0]               hi_byte;
    logic [15:0]              rx_csum;
    logic [15:0]              tot_len;
    logic [15:0]              frag;
    logic [7:0]               proto;
    logic [31:0]              src;
    verdict_t                 verdicts_due[$];
    int                       errors;

    function new();
      errors = 0;
      clear_header();
    endfunction

    function void clear_header();
      pos     = '0;
      sum     = '0;
      hi_byte = '0;
      rx_csum = '0;
      tot_len = '0;
      frag    = '0;
      proto   = '0;
      src     = '0;
    endfunction

    // Fold every carry back in, then complement
    static function logic [15:0] fold_complement(logic [SumW-1:0] s);
      logic [SumW-1:0] t;
      t = s;
      while (t > SumW'(ihc_pkg::WordMask))
        t = SumW'(t[SumW-1:16]) + SumW'(t[15:0]);
      return ~t[15:0];
    endfunction

    // Advance the header state by one accepted byte
    function void note_byte(logic [7:0] b, logic first);
      logic [15:0] word;
      verdict_t    v;
      if (first)
        clear_header();
      if (pos >= ihc_pkg::PosDone)
        return;
      word = {hi_byte, b};
      if (!pos[0]) begin
        hi_byte = b;
      end else if (pos == ihc_pkg::PosCsumLo) begin
        rx_csum = word;
      end else begin
        sum = sum + SumW'(word);
      end
      if (pos == ihc_pkg::PosTotLenLo)
        tot_len = word;
      if (pos == ihc_pkg::PosFragLo)
        frag = word;
      if (pos == ihc_pkg::PosProto)
        proto = b;
      if (pos >= ihc_pkg::PosSrcFirst && pos <= ihc_pkg::PosSrcLast)
        src = {src[23:0], b};
      if (pos == ihc_pkg::PosLast) begin
        if (proto == ihc_pkg::ProtoTcp)
          v.protocol_class = ihc_pkg::ClassTcp;
        else if (proto == ihc_pkg::ProtoUdp)
          v.protocol_class = ihc_pkg::ClassUdp;
        else if (proto == ihc_pkg::ProtoIcmp)
          v.protocol_class = ihc_pkg::ClassIcmp;
        else
          v.protocol_class = ihc_pkg::ClassOther;
        if (fold_complement(sum) != rx_csum)
          v.verdict = ihc_pkg::VerdictBadCsum;
        else if (v.protocol_class == ihc_pkg::ClassOther)
          v.verdict = ihc_pkg::VerdictUnknown;
        else if (v.protocol_class == ihc_pkg::ClassIcmp && frag != 16'h0)
          v.verdict = ihc_pkg::VerdictFragIcmp;
        else
          v.verdict = ihc_pkg::VerdictAccept;
        v.payload_length = (tot_len > 16'(ihc_pkg::HdrBytes))
                         ? tot_len - 16'(ihc_pkg::HdrBytes) : 16'h0;
        v.source_address = src;
        verdicts_due.push_back(v);
      end
      pos = pos + 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Compare one verdict transfer with the oldest queued verdict
    task check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("unexpected verdict %0d class %0d len %0d src %h",
                         got.verdict, got.protocol_class, got.payload_length,
                         got.source_address));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.verdict !== want.verdict)
        report($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
      if (got.protocol_class !== want.protocol_class)
        report($sformatf("protocol_class %0d, want %0d", got.protocol_class,
                         want.protocol_class));
      if (got.payload_length !== want.payload_length)
        report($sformatf("payload_length %0d, want %0d", got.payload_length,
                         want.payload_length));
      if (got.source_address !== want.source_address)
        report($sformatf("source_address %h, want %h", got.source_address,
                         want.source_address));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ihc_in_if  hdr_if ();
  ihc_out_if res_if ();

  ipv4_header_checker_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr_if),
    .res_o  (res_if)
  );

  ipv4_verdict_scoreboard sb = new();

  logic [7:0] frame [0:19];
  int         in_gap      = 0;
  bit         in_idling   = 1'b1;
  bit         out_idling  = 1'b1;
  int         hold_req    = 0;
  int         bytes_sent  = 0;
  int         stall_cycles = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int draw_gap(bit idling);
    return idling ? int'($urandom_range(0, 11)) : 0;
  endfunction

  // Build a 20-byte header around the given fields; other bytes are random or all ones
  function automatic void fill_frame(logic [7:0] proto, logic [15:0] tot_len,
                                     logic [15:0] frag, logic [31:0] src,
                                     bit csum_ok, bit saturate);
    logic [SumW-1:0] acc;
    logic [15:0]     csum;
    int              i;
    for (i = 0; i < ihc_pkg::HdrBytes; i++)
      frame[i] = saturate ? 8'hFF : 8'($urandom);
    frame[ihc_pkg::PosTotLenLo - 1] = tot_len[15:8];
    frame[ihc_pkg::PosTotLenLo]     = tot_len[7:0];
    frame[ihc_pkg::PosFragLo - 1]   = frag[15:8];
    frame[ihc_pkg::PosFragLo]       = frag[7:0];
    frame[ihc_pkg::PosProto]        = proto;
    for (i = 0; i < 4; i++)
      frame[ihc_pkg::PosSrcFirst + i] = src[31 - 8 * i -: 8];
    acc = '0;
    for (i = 0; i < ihc_pkg::HdrBytes; i += 2)
      if (i + 1 != ihc_pkg::PosCsumLo)
        acc = acc + SumW'({frame[i], frame[i + 1]});
    csum = ipv4_verdict_scoreboard::fold_complement(acc);
    if (!csum_ok)
      csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
    frame[ihc_pkg::PosCsumLo - 1] = csum[15:8];
    frame[ihc_pkg::PosCsumLo]     = csum[7:0];
  endfunction

  // Draw header fields with weight on the classes and the length extremes
  function automatic void random_frame();
    logic [7:0]  proto;
    logic [15:0] tot_len;
    logic [15:0] frag;
    case ($urandom_range(0, 4))
      0:       proto = ihc_pkg::ProtoTcp;
      1:       proto = ihc_pkg::ProtoUdp;
      2:       proto = ihc_pkg::ProtoIcmp;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       tot_len = 16'($urandom_range(0, 21));
      1:       tot_len = 16'hFFFF;
      default: tot_len = 16'($urandom);
    endcase
    frag = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom);
    fill_frame(proto, tot_len, frag, $urandom, $urandom_range(0, 3) != 0,
               $urandom_range(0, 7) == 0);
  endfunction

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(logic [7:0] b, logic first);
    if (in_gap > 0)
      repeat (in_gap) @(posedge clk_i);
    hdr_if.valid       <= 1'b1;
    hdr_if.header_byte <= b;
    hdr_if.first_byte  <= first;
    @(posedge clk_i);
    while (!hdr_if.ready)
      @(posedge clk_i);
    sb.note_byte(b, first);
    bytes_sent++;
    in_gap = draw_gap(in_idling);
    if (in_gap > 0)
      hdr_if.valid <= 1'b0;
  endtask

  task automatic send_frame(int nbytes, bit mark_first);
    int i;
    for (i = 0; i < nbytes; i++)
      send_byte(frame[i], mark_first && i == 0);
  endtask

  // Drop valid and wait until every owed verdict has come back
  task automatic drain_verdicts();
    if (in_gap == 0) begin
      hdr_if.valid <= 1'b0;
      in_gap = 1;
    end
    while (sb.verdicts_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Verdict side: random or long hold-offs, then take one transfer and check it
  initial begin
    int       gap;
    verdict_t got;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni)
      @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end else begin
        gap = draw_gap(out_idling);
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid)
        @(posedge clk_i);
      got.verdict        = res_if.verdict;
      got.protocol_class = res_if.protocol_class;
      got.payload_length = res_if.payload_length;
      got.source_address = res_if.source_address;
      sb.check_verdict(got);
      if ($urandom_range(0, 7) == 0)
        out_idling = !out_idling;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Byte side: reset, directed headers, random traffic, drain and verdict
  initial begin
    int iter;
    int i;
    int n;
    hdr_if.valid       = 1'b0;
    hdr_if.header_byte = 8'h00;
    hdr_if.first_byte  = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header with no first flag straight after reset
    fill_frame(ihc_pkg::ProtoTcp, 16'd40, 16'h0, 32'h0A000001, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b0);
    // Classes and length extremes
    fill_frame(ihc_pkg::ProtoUdp, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    fill_frame(ihc_pkg::ProtoIcmp, 16'd20, 16'h0, 32'h0, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // Fragmented ICMP
    fill_frame(ihc_pkg::ProtoIcmp, 16'd21, 16'h4000, $urandom, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // Unknown protocols, length below the header size
    fill_frame(8'h00, 16'h0, 16'h0, $urandom, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    fill_frame(8'hFF, 16'd19, 16'h0, $urandom, 1'b1, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // Bad checksum wins over the protocol checks
    fill_frame(ihc_pkg::ProtoTcp, 16'd60, 16'h0, $urandom, 1'b0, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    fill_frame(8'h2F, 16'd60, 16'h0, $urandom, 1'b0, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    fill_frame(ihc_pkg::ProtoIcmp, 16'd84, 16'h2000, $urandom, 1'b0, 1'b0);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // All-ones header whose sum needs a second carry fold
    fill_frame(ihc_pkg::ProtoTcp, 16'h00FA, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // First flag in mid-header restarts the header
    random_frame();
    send_frame(7, 1'b1);
    random_frame();
    send_frame(ihc_pkg::HdrBytes, 1'b1);
    // Trailing bytes after byte 19 are ignored
    for (i = 0; i < 3; i++)
      send_byte(8'($urandom), 1'b0);

    // Random traffic: mostly well-formed headers, some noise and broken ones
    iter = 0;
    while (bytes_sent < ByteBudget) begin
      if ($urandom_range(0, 3) == 0)
        in_idling = !in_idling;
      if (iter == 12) begin
        // Hold the verdict side off while headers keep coming
        hold_req = HoldCycles;
        for (i = 0; i < 6; i++) begin
          random_frame();
          send_frame(ihc_pkg::HdrBytes, 1'b1);
        end
        drain_verdicts();
      end
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        1: begin
          random_frame();
          send_frame($urandom_range(1, ihc_pkg::HdrBytes - 1), 1'b1);
        end
        default: begin
          random_frame();
          send_frame(ihc_pkg::HdrBytes, $urandom_range(0, 9) != 0);
          if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
              send_byte(8'($urandom), 1'b0);
          end
        end
      endcase
      iter++;
    end

    drain_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
